@@ rtl/pcrf_pkg.sv @@
// Package for the pressure climb rate filter.
// Holds fixed-point constants, register indexes, reset values, the coefficient
// struct and the shift/saturate helpers. Depends on nothing.
`default_nettype none

package pcrf_pkg;

	localparam int COEF_FRAC_BITS = 22;
	localparam int RATE_FRAC_BITS = 16;

	// Scaling of gain * diff into a Q16.16 rate: one of the two shifts is zero.
	localparam int RATE_SHR = (COEF_FRAC_BITS >= RATE_FRAC_BITS) ?
		(COEF_FRAC_BITS - RATE_FRAC_BITS) : 0;
	localparam int RATE_SHL = (RATE_FRAC_BITS > COEF_FRAC_BITS) ?
		(RATE_FRAC_BITS - COEF_FRAC_BITS) : 0;

	localparam int GAIN_W  = 23;
	localparam int COEF_W  = 24;
	localparam int PRESS_W = 17;
	localparam int DIFF_W  = PRESS_W + 1;
	localparam int RATE_W  = 32;
	localparam int PROD_W  = COEF_W + RATE_W;
	localparam int ACC_W   = PROD_W + 4;
	localparam int IDX_W   = 3;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_GAIN = 3'd0;
	localparam logic [IDX_W-1:0] REG_FF0  = 3'd1;
	localparam logic [IDX_W-1:0] REG_FF1  = 3'd2;
	localparam logic [IDX_W-1:0] REG_FF2  = 3'd3;
	localparam logic [IDX_W-1:0] REG_FB1  = 3'd4;
	localparam logic [IDX_W-1:0] REG_FB2  = 3'd5;

	localparam logic [GAIN_W-1:0]        GAIN_RST = 23'd3711773;
	localparam logic signed [COEF_W-1:0] FF0_RST  = 24'sd84236;
	localparam logic signed [COEF_W-1:0] FF1_RST  = 24'sd168471;
	localparam logic signed [COEF_W-1:0] FF2_RST  = 24'sd84236;
	localparam logic signed [COEF_W-1:0] FB1_RST  = -24'sd6547384;
	localparam logic signed [COEF_W-1:0] FB2_RST  = 24'sd2690023;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [GAIN_W-1:0]        gain;
		logic signed [COEF_W-1:0] ff0;
		logic signed [COEF_W-1:0] ff1;
		logic signed [COEF_W-1:0] ff2;
		logic signed [COEF_W-1:0] fb1;
		logic signed [COEF_W-1:0] fb2;
	} pcrf_coef_t;

	// Clamp a wide signed value to signed 32 bits.
	function automatic logic signed [RATE_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [RATE_W-1:0] r;
		if (v > SAT_MAX)
			r = SAT_MAX[RATE_W-1:0];
		else if (v < SAT_MIN)
			r = SAT_MIN[RATE_W-1:0];
		else
			r = v[RATE_W-1:0];
		return r;
	endfunction

	// Turn gain * pressure difference into a saturated Q16.16 raw rate.
	// The arithmetic right shift is a floor, as required.
	function automatic logic signed [RATE_W-1:0] rate_scale(
		input logic signed [PROD_W-1:0] p);
		logic signed [63:0] w;
		w = {{(64-PROD_W){p[PROD_W-1]}}, p};
		w = (w >>> RATE_SHR) <<< RATE_SHL;
		return sat32(w);
	endfunction

	// Drop the coefficient fraction bits of the accumulator and saturate.
	function automatic logic signed [RATE_W-1:0] acc_scale(
		input logic signed [ACC_W-1:0] a);
		logic signed [63:0] w;
		w = {{(64-ACC_W){a[ACC_W-1]}}, a};
		w = w >>> COEF_FRAC_BITS;
		return sat32(w);
	endfunction

endpackage

`default_nettype wire

@@ rtl/pcrf_top.sv @@
// An accepted pressure request goes through nine sequencer steps on the shared
// multiplier and one output load before m_tvalid; m_tready can stall the load.
// The single shared multiplier does six products per sample. s_tready is low
// while a sample is being worked, so a new request waits for the last one.
// Reset (arst_n low, asynchronous): registers return to their defaults, the
// filter history clears and the next sample only primes the previous pressure.
`default_nettype none

module pressure_climb_rate_filter_top import pcrf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Pressure requests.
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [23:0]        s_tdata,   // [16:0] pressure_pa, rest zero
	// Filtered climb rate results.
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [31:0]             m_tdata,   // [31:0] climb_rate
	// Configuration writes.
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [COEF_W-1:0]  cfg_data
);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// Steps within ST_RUN. The multiplier result of one step is accumulated
	// in the next one.
	localparam logic [3:0] STEP_GAIN = 4'd0;  // gain * diff
	localparam logic [3:0] STEP_X0   = 4'd1;  // scale raw rate, clear accumulator
	localparam logic [3:0] STEP_FF0  = 4'd2;
	localparam logic [3:0] STEP_FF1  = 4'd3;
	localparam logic [3:0] STEP_FF2  = 4'd4;
	localparam logic [3:0] STEP_FB1  = 4'd5;
	localparam logic [3:0] STEP_FB2  = 4'd6;
	localparam logic [3:0] STEP_TAIL = 4'd7;  // accumulate last product
	localparam logic [3:0] STEP_END  = 4'd8;

	pcrf_coef_t coef;

	logic [1:0]                state_q;
	logic [3:0]                step_q;
	logic                      first_q;
	logic [PRESS_W-1:0]        prev_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [RATE_W-1:0]  x0_q;
	logic signed [RATE_W-1:0]  in_hist0_q, in_hist1_q;
	logic signed [RATE_W-1:0]  out_hist0_q, out_hist1_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      m_valid_q;
	logic [RATE_W-1:0]         m_data_q;

	logic signed [COEF_W-1:0]  mul_a;
	logic signed [RATE_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [RATE_W-1:0]  y0;
	logic [PRESS_W-1:0]        press_in;
	logic                      in_fire;
	logic                      out_free;
	logic                      out_load;

	assign cfg_ready = 1'b1;

	pcrf_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			STEP_GAIN: begin
				mul_a = COEF_W'(coef.gain);
				mul_b = RATE_W'(diff_q);
			end
			STEP_FF0: begin
				mul_a = coef.ff0;
				mul_b = x0_q;
			end
			STEP_FF1: begin
				mul_a = coef.ff1;
				mul_b = in_hist0_q;
			end
			STEP_FF2: begin
				mul_a = coef.ff2;
				mul_b = in_hist1_q;
			end
			STEP_FB1: begin
				mul_a = coef.fb1;
				mul_b = out_hist0_q;
			end
			STEP_FB2: begin
				mul_a = coef.fb2;
				mul_b = out_hist1_q;
			end
			default: ;
		endcase
	end

	pcrf_mul u_mul (
		.clk (clk),
		.en  (state_q == ST_RUN),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
	assign y0       = acc_scale(acc_q);
	assign press_in = s_tdata[PRESS_W-1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	// The finished result moves into the output register in this cycle.
	assign out_load = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_GAIN;
			first_q     <= 1'b1;
			prev_q      <= '0;
			diff_q      <= '0;
			x0_q        <= '0;
			acc_q       <= '0;
			in_hist0_q  <= '0;
			in_hist1_q  <= '0;
			out_hist0_q <= '0;
			out_hist1_q <= '0;
			m_valid_q   <= 1'b0;
			m_data_q    <= '0;
		end else begin
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						prev_q <= press_in;
						// The first sample after reset only primes the previous pressure.
						if (first_q) begin
							first_q <= 1'b0;
						end else begin
							diff_q  <= signed'({1'b0, prev_q}) - signed'({1'b0, press_in});
							step_q  <= STEP_GAIN;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					case (step_q)
						STEP_X0: begin
							x0_q  <= rate_scale(prod);
							acc_q <= '0;
						end
						STEP_FF1, STEP_FF2, STEP_FB1: acc_q <= acc_q + prod_ext;
						STEP_FB2, STEP_TAIL:          acc_q <= acc_q - prod_ext;
						default: ;
					endcase
					if (step_q == STEP_END)
						state_q <= ST_DONE;
					else
						step_q <= step_q + 4'd1;
				end
				ST_DONE: begin
					// Hold the finished result until the output register is free.
					if (out_free) begin
						m_data_q    <= y0;
						in_hist1_q  <= in_hist0_q;
						in_hist0_q  <= x0_q;
						out_hist1_q <= out_hist0_q;
						out_hist0_q <= y0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire

@@ rtl/pcrf_regs.sv @@
// Configuration register file for the climb rate filter: gain and biquad
// coefficients. Depends on pcrf_pkg.
`default_nettype none

module pcrf_regs import pcrf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [IDX_W-1:0]   wr_index,
	input  wire logic [COEF_W-1:0]  wr_data,
	output pcrf_coef_t              coef
);

	pcrf_coef_t coef_q;

	// Indexes past the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.gain <= GAIN_RST;
			coef_q.ff0  <= FF0_RST;
			coef_q.ff1  <= FF1_RST;
			coef_q.ff2  <= FF2_RST;
			coef_q.fb1  <= FB1_RST;
			coef_q.fb2  <= FB2_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_GAIN: coef_q.gain <= wr_data[GAIN_W-1:0];
				REG_FF0:  coef_q.ff0  <= wr_data;
				REG_FF1:  coef_q.ff1  <= wr_data;
				REG_FF2:  coef_q.ff2  <= wr_data;
				REG_FB1:  coef_q.fb1  <= wr_data;
				REG_FB2:  coef_q.fb2  <= wr_data;
				default:  ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

@@ rtl/pcrf_mul.sv @@
// Shared signed multiplier with a registered product, used for the gain
// product and all five filter taps. Depends on pcrf_pkg.
`default_nettype none

module pcrf_mul import pcrf_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic signed [COEF_W-1:0]  a,
	input  wire logic signed [RATE_W-1:0]  b,
	output logic signed [PROD_W-1:0]       p
);

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en)
			p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for pressure_climb_rate_filter_top.
// It predicts every filtered climb rate from the accepted pressure requests and the
// registers written so far. It needs only pcrf_pkg and the top level.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pcrf_pkg::*;

	localparam int S_W = 24;
	localparam int CYCLE_LIMIT = 1000000;
	// The block holds a finished result while m_tready is low, so a stretch this
	// long is enough for the pending pressure request to be refused.
	localparam int HOLD_OFF = 400;
	// Quiet time before a register write. It covers the latency of the block.
	localparam int SETTLE = 16;
	localparam int P_MAX = (1 << PRESS_W) - 1;
	localparam logic [PRESS_W-1:0] P_TOP = PRESS_W'(P_MAX);
	localparam longint RATE_MAX = 64'sd2147483647;
	localparam longint RATE_MIN = -64'sd2147483648;
	// Indexes past the last register. Writes to them must change nothing.
	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [S_W-1:0]     s_tdata = '0;     // [16:0] pressure_pa, rest zero
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [RATE_W-1:0]  m_tdata;          // [31:0] climb_rate
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [COEF_W-1:0]  cfg_data = '0;

	pressure_climb_rate_filter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Pressure samples that still have to be offered to the block.
	logic [PRESS_W-1:0] pressure_q[$];
	// Climb rates that the block still owes, oldest first.
	logic [RATE_W-1:0] climb_q[$];

	// Shadow of the block's state: the registers, the previous pressure and the two
	// delay lines of the direct-form-I filter.
	pcrf_coef_t coef_set;
	bit                 primed;
	logic [PRESS_W-1:0] last_pa;
	longint             raw_hist[2];
	longint             speed_hist[2];

	int n_accepted = 0;
	int n_checked  = 0;
	int n_writes   = 0;
	int n_clamped  = 0;
	int n_errors   = 0;
	int cycles     = 0;

	function automatic longint clamp_rate(input longint v);
		if (v > RATE_MAX)
			return RATE_MAX;
		if (v < RATE_MIN)
			return RATE_MIN;
		return v;
	endfunction

	// Register write as the block sees it. The gain keeps its low 23 bits, and
	// spare indexes are ignored.
	function automatic void apply_reg(input logic [IDX_W-1:0] idx,
		input logic [COEF_W-1:0] data);
		case (idx)
			REG_GAIN: coef_set.gain = data[GAIN_W-1:0];
			REG_FF0:  coef_set.ff0 = data;
			REG_FF1:  coef_set.ff1 = data;
			REG_FF2:  coef_set.ff2 = data;
			REG_FB1:  coef_set.fb1 = data;
			REG_FB2:  coef_set.fb2 = data;
			default: ;
		endcase
	endfunction

	// One accepted pressure sample. The first one after reset only primes the
	// previous pressure. Each later sample gives one filtered climb rate.
	function automatic void climb_predict(input logic [PRESS_W-1:0] pa);
		longint diff;
		longint raw;
		longint acc;
		longint speed;
		if (!primed) begin
			primed = 1'b1;
			last_pa = pa;
			return;
		end
		diff = longint'(last_pa) - longint'(pa);
		last_pa = pa;
		// The arithmetic shift of a signed value is a floor, which is the rounding
		// that the block uses.
		raw = clamp_rate(((diff * longint'(coef_set.gain)) >>> RATE_SHR) <<< RATE_SHL);
		acc = longint'(coef_set.ff0) * raw
			+ longint'(coef_set.ff1) * raw_hist[0]
			+ longint'(coef_set.ff2) * raw_hist[1]
			- longint'(coef_set.fb1) * speed_hist[0]
			- longint'(coef_set.fb2) * speed_hist[1];
		speed = clamp_rate(acc >>> COEF_FRAC_BITS);
		if (speed != (acc >>> COEF_FRAC_BITS))
			n_clamped++;
		raw_hist[1] = raw_hist[0];
		raw_hist[0] = raw;
		speed_hist[1] = speed_hist[0];
		speed_hist[0] = speed;
		climb_q.push_back(speed[RATE_W-1:0]);
	endfunction

	// Idle lengths: mostly none or short, now and then a long one. In a calm
	// stretch there are none at all.
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Pressure driver. A new request goes out only once the previous one has been
	// taken. tvalid is never dropped while a request is waiting.
	int send_wait = 0;
	int send_span = 0;
	bit send_calm = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				climb_predict(s_tdata[PRESS_W-1:0]);
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_wait > 0) begin
					send_wait--;
					s_tvalid <= 1'b0;
				end else if (pressure_q.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {{(S_W-PRESS_W){1'b0}}, pressure_q.pop_front()};
					send_wait = pick_gap(send_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (send_span == 0) begin
				send_calm = ($urandom_range(0, 3) == 0);
				send_span = $urandom_range(50, 300);
			end else begin
				send_span--;
			end
		end
	end

	// Result side ready. It pauses at random after each result. Three times in the
	// run it holds off for a long stretch while the sender keeps offering, so the
	// block fills up and stalls its input.
	int take_wait = 0;
	int take_span = 0;
	int n_drained = 0;
	bit take_calm = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_drained++;
				if (n_drained % 700 == 350)
					take_wait = HOLD_OFF;
				else
					take_wait = pick_gap(take_calm);
			end
			if (take_wait > 0) begin
				take_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			if (take_span == 0) begin
				take_calm = ($urandom_range(0, 3) == 0);
				take_span = $urandom_range(50, 300);
			end else begin
				take_span--;
			end
		end
	end

	// Result checker. Each accepted climb rate is compared with the oldest prediction.
	logic [RATE_W-1:0] want;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_checked++;
			if (climb_q.size() == 0) begin
				$display("%0t: climb rate %0d with none expected", $time, $signed(m_tdata));
				n_errors++;
			end else begin
				want = climb_q.pop_front();
				if (m_tdata !== want) begin
					$display("%0t: climb_rate expected %0d, got %0d", $time,
						$signed(want), $signed(m_tdata));
					n_errors++;
				end
			end
		end
	end

	// Watchdog. A hang or a lost result ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles, climb_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Write one register when the block is idle. The shadow copy changes at the
	// same edge as the block's copy.
	task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		n_writes++;
		cfg_valid <= 1'b0;
	endtask

	// Wait until every request has been taken and every result checked. Then let
	// the pipeline drain.
	task automatic wait_idle();
		do @(negedge clk); while (pressure_q.size() > 0 || s_tvalid || climb_q.size() > 0);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_all(input logic [COEF_W-1:0] g, input logic [COEF_W-1:0] f0,
		input logic [COEF_W-1:0] f1, input logic [COEF_W-1:0] f2,
		input logic [COEF_W-1:0] b1, input logic [COEF_W-1:0] b2);
		reg_write(REG_GAIN, g);
		reg_write(REG_FF0, f0);
		reg_write(REG_FF1, f1);
		reg_write(REG_FF2, f2);
		reg_write(REG_FB1, b1);
		reg_write(REG_FB2, b2);
		@(negedge clk);
	endtask

	// Mostly a slow drift like real air pressure. Sometimes a jump anywhere in
	// range, and sometimes a rail value that drives the raw rate into saturation.
	function automatic void push_walk(input int count, inout int pa);
		int r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				pa = pa + $urandom_range(0, 80) - 40;
			else if (r < 95)
				pa = $urandom_range(0, P_MAX);
			else
				pa = r[0] ? 0 : P_MAX;
			if (pa < 0)
				pa = 0;
			if (pa > P_MAX)
				pa = P_MAX;
			pressure_q.push_back(pa[PRESS_W-1:0]);
		end
	endfunction

	initial begin
		int pa;
		int mode;
		coef_set = '{gain: GAIN_RST, ff0: FF0_RST, ff1: FF1_RST, ff2: FF2_RST,
			fb1: FB1_RST, fb2: FB2_RST};
		primed = 1'b0;
		last_pa = '0;
		raw_hist = '{0, 0};
		speed_hist = '{0, 0};
		pa = 101325;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values. The first sample only primes. Then come no change, a small
		// climb, and full-scale steps both ways that clamp the raw rate.
		pressure_q = '{17'd101325, 17'd101325, 17'd101300, P_TOP, 17'd0, 17'd0, P_TOP,
			17'd1, P_TOP - 17'd1, 17'd65536};
		wait_idle();

		// Largest gain, with bit 23 of the write set so that only the low bits must
		// count. The coefficients sit on their rails, so the output saturates.
		write_all(24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
		pressure_q = '{17'd0, P_TOP, 17'd0, P_TOP, 17'd43690, 17'd87381};
		wait_idle();

		// Zero gain. The saturated history keeps circulating through the feedback
		// terms. Writes to the spare indexes must be ignored.
		write_all(24'h000000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
		reg_write(REG_SPARE_A, COEF_W'($urandom));
		reg_write(REG_SPARE_B, COEF_W'($urandom));
		@(negedge clk);
		pressure_q = '{17'd1000, 17'd2000, P_TOP, 17'd0, 17'd5};
		wait_idle();

		// Random phases. Each one starts with a register setting: the reset values,
		// the reset filter with a random gain, or everything random.
		for (int ph = 0; ph < 6; ph++) begin
			mode = (ph == 0) ? 0 : $urandom_range(0, 2);
			case (mode)
				0: write_all(COEF_W'(GAIN_RST), FF0_RST, FF1_RST, FF2_RST, FB1_RST, FB2_RST);
				1: write_all(COEF_W'($urandom), FF0_RST, FF1_RST, FF2_RST, FB1_RST, FB2_RST);
				default: write_all(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
					COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
			endcase
			if ($urandom_range(0, 2) == 0) begin
				reg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					COEF_W'($urandom));
				@(negedge clk);
			end
			push_walk(330, pa);
			wait_idle();
		end

		$display("Checked %0d climb rates from %0d pressure requests over %0d register writes,",
			n_checked, n_accepted, n_writes);
		$display("%0d of them clamped at the output rails; %0d mismatches.", n_clamped, n_errors);
		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/pcrf_pkg.sv
rtl/pcrf_regs.sv
rtl/pcrf_mul.sv
rtl/pcrf_top.sv
tb/testbench.sv
